// File: hdl/first_match_fixed_length_replace_unit_assert.svh
// ----------------------------------------------------------------------------
// first_match_fixed_length_replace_unit_assert
// assertion macros for the first-match replace unit, clocked on clk and
// disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef FIRST_MATCH_FIXED_LENGTH_REPLACE_UNIT_ASSERT_SVH
`define FIRST_MATCH_FIXED_LENGTH_REPLACE_UNIT_ASSERT_SVH

// condition holds at every edge
`define FMR_ASSERT_ALWAYS(lbl, cond, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define FMR_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/fmr_pkg.sv
// ----------------------------------------------------------------------------
// fmr_pkg
// shared constants, types and helpers of the first-match replace unit
// ----------------------------------------------------------------------------
package fmr_pkg;

	localparam int LEN_CAP   = 16;
	localparam int BUF_DEPTH = 32;
	localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
	localparam int IDX_W     = $clog2(BUF_DEPTH);

	localparam logic [2:0] CFG_PATTERN_LOW      = 3'd0;
	localparam logic [2:0] CFG_PATTERN_HIGH     = 3'd1;
	localparam logic [2:0] CFG_REPLACEMENT_LOW  = 3'd2;
	localparam logic [2:0] CFG_REPLACEMENT_HIGH = 3'd3;
	localparam logic [2:0] CFG_PATTERN_LENGTH   = 3'd4;

	typedef logic [LEN_CAP-2:0][7:0] win_t;
	typedef logic [LEN_CAP-1:0][7:0] cand_t;

	typedef struct packed {
		logic  hit;
		cand_t bytes;
	} match_t;

	typedef struct packed {
		logic [6:0] pos;
		logic       found;
		logic       last;
		logic [7:0] data;
	} entry_t;

	function automatic logic [7:0] pick_byte(input logic [8*LEN_CAP-1:0] v, input logic [3:0] k);
		return v[k*8 +: 8];
	endfunction

endpackage

// File: hdl/fmr_match.sv
// ----------------------------------------------------------------------------
// fmr_match
// compares the newest bytes with the pattern and applies the replacement
// ----------------------------------------------------------------------------
module fmr_match (
	input  logic [7:0]                       new_byte,
	input  fmr_pkg::win_t                    window,
	input  logic [3:0]                       fill,
	input  logic [4:0]                       len,
	input  logic                             enable,
	input  logic [8*fmr_pkg::LEN_CAP-1:0]    pattern,
	input  logic [8*fmr_pkg::LEN_CAP-1:0]    replacement,
	output fmr_pkg::match_t                  result
);

	always_comb begin
		fmr_pkg::cand_t               cand;
		logic [fmr_pkg::LEN_CAP-1:0] eq;
		logic [fmr_pkg::LEN_CAP-1:0] in_use;
		logic [fmr_pkg::LEN_CAP-1:0][3:0] idx;
		logic [4:0]                   tmp;
		cand[0] = new_byte;
		for (int j = 1; j < fmr_pkg::LEN_CAP; j++) begin
			cand[j] = window[j-1];
		end
		for (int j = 0; j < fmr_pkg::LEN_CAP; j++) begin
			tmp       = len - 5'd1 - 5'(j);
			idx[j]    = tmp[3:0];
			in_use[j] = 5'(j) < len;
			eq[j]     = cand[j] == fmr_pkg::pick_byte(pattern, idx[j]);
		end
		result.hit = enable && (({1'b0, fill} + 5'd1) >= len) && (&(eq | ~in_use));
		for (int j = 0; j < fmr_pkg::LEN_CAP; j++) begin
			result.bytes[j] = (result.hit && in_use[j]) ?
				fmr_pkg::pick_byte(replacement, idx[j]) : cand[j];
		end
	end

endmodule

// File: hdl/first_match_fixed_length_replace_unit.sv
// ----------------------------------------------------------------------------
// first_match_fixed_length_replace_unit
// streams chunk bytes, replaces the first whole-chunk match of the pattern
// ----------------------------------------------------------------------------
// Takes one byte per cycle and sustains one byte per cycle out while the
// output is not stalled. A byte leaves once pattern_length - 1 newer bytes
// have arrived, or at the end of its chunk, and passes through the input
// register, the hold buffer and the output register. Bytes wait in a 32-entry
// hold buffer (window plus bytes ready to leave); the input stalls only when
// that buffer is full, which happens only while the output side is stalled.
// The end of a chunk releases up to 16 bytes at once; while the output is
// not stalled they drain at one per cycle as the next chunk streams in. The
// last beat of a chunk carries the found flag and match start offset in m_tdata.
// ----------------------------------------------------------------------------
`include "first_match_fixed_length_replace_unit_assert.svh"

module first_match_fixed_length_replace_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // in_byte
	input  logic        s_tlast,   // end_of_chunk
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // out_byte, found, match_position
	output logic        m_tlast,   // last
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [63:0] pattern_low_q, pattern_high_q;
	logic [63:0] replacement_low_q, replacement_high_q;
	logic [4:0]  pattern_length_q;
	logic [4:0]  len;

	logic       in_valid_s1;
	logic [7:0] in_byte_s1;
	logic       in_end_s1;

	fmr_pkg::entry_t [fmr_pkg::BUF_DEPTH-1:0] ent_q;
	fmr_pkg::entry_t [fmr_pkg::BUF_DEPTH-1:0] ent_shift;
	fmr_pkg::entry_t                          out_ent_q;
	logic                                     out_valid_q;
	logic [fmr_pkg::CNT_W-1:0]                count_q;
	logic [fmr_pkg::CNT_W-1:0]                count_m1;
	logic [fmr_pkg::IDX_W-1:0]                rd_idx;
	logic [3:0]                               fill_q;
	logic                                     replaced_q;
	logic [6:0]                               byte_pos_q;
	logic [6:0]                               found_pos_q;

	fmr_pkg::win_t   window;
	fmr_pkg::match_t mres;
	logic            step_go;
	logic            pop;
	logic            replaced_next;
	logic [6:0]      found_pos_next;
	logic [4:0]      fill_inc;
	logic [4:0]      len_m1;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q      <= '0;
			pattern_high_q     <= '0;
			replacement_low_q  <= '0;
			replacement_high_q <= '0;
			pattern_length_q   <= 5'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				fmr_pkg::CFG_PATTERN_LOW:      pattern_low_q      <= cfg_data;
				fmr_pkg::CFG_PATTERN_HIGH:     pattern_high_q     <= cfg_data;
				fmr_pkg::CFG_REPLACEMENT_LOW:  replacement_low_q  <= cfg_data;
				fmr_pkg::CFG_REPLACEMENT_HIGH: replacement_high_q <= cfg_data;
				fmr_pkg::CFG_PATTERN_LENGTH:   pattern_length_q   <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (pattern_length_q == 5'd0) begin
			len = 5'd1;
		end else if (pattern_length_q > 5'(fmr_pkg::LEN_CAP)) begin
			len = 5'(fmr_pkg::LEN_CAP);
		end else begin
			len = pattern_length_q;
		end
	end

	// input register
	assign step_go  = in_valid_s1 && (count_q != fmr_pkg::CNT_W'(fmr_pkg::BUF_DEPTH));
	assign s_tready = !in_valid_s1 || step_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_byte_s1 <= s_tdata;
			in_end_s1  <= s_tlast;
		end
	end

	// compare and replace
	always_comb begin
		for (int j = 0; j < fmr_pkg::LEN_CAP - 1; j++) begin
			window[j] = ent_q[j].data;
		end
	end

	fmr_match u_match (
		.new_byte    (in_byte_s1),
		.window      (window),
		.fill        (fill_q),
		.len         (len),
		.enable      (!replaced_q),
		.pattern     ({pattern_high_q, pattern_low_q}),
		.replacement ({replacement_high_q, replacement_low_q}),
		.result      (mres)
	);

	assign replaced_next  = replaced_q || mres.hit;
	assign found_pos_next = mres.hit ? (byte_pos_q + 7'd1 - 7'(len)) : found_pos_q;
	assign fill_inc       = {1'b0, fill_q} + 5'd1;
	assign len_m1         = len - 5'd1;

	// hold buffer shifted by one new entry, newest at index 0
	always_comb begin
		ent_shift[0].data  = mres.bytes[0];
		ent_shift[0].last  = in_end_s1;
		ent_shift[0].found = in_end_s1 && replaced_next;
		ent_shift[0].pos   = (in_end_s1 && replaced_next) ? found_pos_next : 7'd0;
		for (int j = 1; j < fmr_pkg::BUF_DEPTH; j++) begin
			ent_shift[j] = ent_q[j-1];
		end
		for (int j = 1; j < fmr_pkg::LEN_CAP; j++) begin
			ent_shift[j].data = mres.bytes[j];
		end
	end

	always_ff @(posedge clk) begin
		if (step_go) begin
			ent_q <= ent_shift;
		end
	end

	// output side
	assign count_m1 = count_q - fmr_pkg::CNT_W'(1);
	assign rd_idx   = count_m1[fmr_pkg::IDX_W-1:0];
	assign pop      = (count_q > fmr_pkg::CNT_W'(fill_q)) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_ent_q <= ent_q[rd_idx];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_ent_q.pos, out_ent_q.found, out_ent_q.data};
	assign m_tlast  = out_ent_q.last;

	// chunk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			fill_q      <= '0;
			replaced_q  <= 1'b0;
			byte_pos_q  <= '0;
			found_pos_q <= '0;
		end else begin
			count_q <= count_q + fmr_pkg::CNT_W'(step_go) - fmr_pkg::CNT_W'(pop);
			if (step_go) begin
				if (in_end_s1) begin
					fill_q      <= '0;
					replaced_q  <= 1'b0;
					byte_pos_q  <= '0;
					found_pos_q <= '0;
				end else begin
					fill_q      <= (fill_inc < len) ? fill_inc[3:0] : len_m1[3:0];
					replaced_q  <= replaced_next;
					byte_pos_q  <= byte_pos_q + 7'd1;
					found_pos_q <= found_pos_next;
				end
			end
		end
	end

	`FMR_ASSERT_ALWAYS(a_fill_within_count, (fmr_pkg::CNT_W'(fill_q) <= count_q), "window exceeds hold buffer")
	`FMR_ASSERT_ALWAYS(a_count_bound, (count_q <= fmr_pkg::CNT_W'(fmr_pkg::BUF_DEPTH)), "hold buffer overflow")
	`FMR_ASSERT_ALWAYS(a_found_on_last, (!(m_tvalid && m_tdata[8]) || m_tlast), "found flag on non-last beat")
	`FMR_ASSERT_NEXT(a_chunk_end_clears, (step_go && in_end_s1), (fill_q == 4'd0 && !replaced_q), "chunk end did not clear state")

endmodule
